@@ src/nearest_center_assign_top_assert.svh @@
// Assertion macros for the nearest-centre assignment checker.
`ifndef NEAREST_CENTER_ASSIGN_TOP_ASSERT_SVH
`define NEAREST_CENTER_ASSIGN_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define NCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define NCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/nca_pkg.sv @@
// Shared types and constants for the nearest-centre assignment block.
`default_nettype none

package nca_pkg;

  localparam int CoordBits   = 16;
  localparam int SlotBits    = 4;
  localparam int IndexBits   = 4;
  localparam int CountBits   = 5;
  localparam int CapBits     = 33;
  localparam int CostOutBits = 48;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 33;

  localparam int MaxCentersDef = 16;
  localparam int CostBitsDef   = 48;

  localparam logic [CapBits-1:0] CapReset = CapBits'(1000000);

  localparam logic [CfgIdxBits-1:0] RegCount = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegCap   = 1'b1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                        command;
    logic [SlotBits-1:0]         center_slot;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic                        eligible_flag;
    logic                        last_point;
  } item_t;

  typedef struct packed {
    logic [IndexBits-1:0]   nearest_index;
    logic [CapBits-1:0]     min_distance;
    logic                   found;
    logic [CostOutBits-1:0] batch_cost;
    logic                   batch_end;
  } result_t;

  // One table entry: usable mark and coordinates.
  typedef struct packed {
    logic                        usable;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } entry_t;

  // Search engine status towards the sequencer.
  typedef struct packed {
    logic               done;
    logic               hit;
    logic [CapBits-1:0] best_dist;
  } search_status_t;

endpackage

`default_nettype wire

@@ src/nearest_center_assign_top.sv @@
// Top level of the nearest-centre assignment block.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      nca_pkg::item_t
//   result    out        result_valid / result_stall  nca_pkg::result_t
//   config    in         cfg_write                    cfg_index, cfg_data
//
// A load beat gives no result.
// A query beat holds item_stall from accept until the state machine is back
// in idle, where the next beat is taken: the single table read port serves
// one entry a cycle, then come the two pipeline stages, the done check and
// the cost update.
// rst is synchronous: it clears the usable marks, cost, count and handshake
// state, sets the cap to CapReset; the coordinate memory keeps its contents.
// A finished result waits in the output register under result_stall while
// the next beat is taken; a second query then holds in its cost cycle.
`default_nettype none

module nearest_center_assign_top #(
  parameter int MAX_CENTERS = nca_pkg::MaxCentersDef,
  parameter int COST_BITS   = nca_pkg::CostBitsDef
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire nca_pkg::item_t                  item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output nca_pkg::result_t                     result,
  input  wire logic                            cfg_write,
  input  wire logic [nca_pkg::CfgIdxBits-1:0]  cfg_index,
  input  wire logic [nca_pkg::CfgDataBits-1:0] cfg_data
);
  import nca_pkg::*;

  localparam int IdxW = $clog2(MAX_CENTERS);
  localparam int CmpW = (IdxW + 1 > CountBits) ? IdxW + 1 : CountBits;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_COST = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [CountBits-1:0] center_count;
  logic [CapBits-1:0]   distance_cap;

  // query held for the length of the scan
  logic signed [CoordBits-1:0] px;
  logic signed [CoordBits-1:0] py;
  logic                        last;

  logic [COST_BITS-1:0] cost_acc;
  logic [COST_BITS:0]   cost_sum;
  logic [COST_BITS-1:0] cost_new;

  logic            accept;
  logic            is_query;
  logic            slot_ok;
  logic            wr_en;
  logic            start;
  logic            out_free;
  logic            load_out;
  logic [CmpW-1:0] count_w;
  logic [CmpW-1:0] max_w;
  logic [IdxW:0]   scan_len;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_entry;
  entry_t          wr_entry;
  search_status_t  status;
  logic [IdxW-1:0] best_idx;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_query   = (item.command == CMD_QUERY);
  assign start      = accept && is_query;

  // loads past the table depth are dropped
  assign slot_ok = (32'(item.center_slot) < MAX_CENTERS);
  assign wr_en   = accept && !is_query && slot_ok;

  assign wr_entry.usable = item.eligible_flag;
  assign wr_entry.x      = item.coord_x;
  assign wr_entry.y      = item.coord_y;

  // centre count clipped to the table depth
  assign count_w  = CmpW'(center_count);
  assign max_w    = CmpW'(MAX_CENTERS);
  assign scan_len = (IdxW + 1)'((count_w > max_w) ? max_w : count_w);

  nca_table #(
    .MAX_CENTERS (MAX_CENTERS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (IdxW'(item.center_slot)),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  nca_search #(
    .MAX_CENTERS (MAX_CENTERS)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .scan_len (scan_len),
    .cap      (distance_cap),
    .px       (px),
    .py       (py),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .status   (status),
    .best_idx (best_idx)
  );

  // saturating cost: both operands fit, so the carry alone flags overflow
  assign cost_sum = (COST_BITS + 1)'(cost_acc) + (COST_BITS + 1)'(status.best_dist);
  assign cost_new = cost_sum[COST_BITS] ? '1 : cost_sum[COST_BITS-1:0];

  assign out_free = !result_valid || !result_stall;
  assign load_out = (state == ST_COST) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.done) state_next = ST_COST;
      end
      ST_COST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      cost_acc     <= '0;
      center_count <= '0;
      distance_cap <= CapReset;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
        cost_acc     <= last ? '0 : cost_new;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          RegCount: center_count <= cfg_data[CountBits-1:0];
          RegCap:   distance_cap <= cfg_data[CapBits-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px   <= item.coord_x;
      py   <= item.coord_y;
      last <= item.last_point;
    end
    if (load_out) begin
      result.nearest_index <= IndexBits'(best_idx);
      result.min_distance  <= status.best_dist;
      result.found         <= status.hit;
      result.batch_cost    <= CostOutBits'(cost_new);
      result.batch_end     <= last;
    end
  end

endmodule

`default_nettype wire

@@ src/nca_table.sv @@
// Centre table: coordinate memory with registered read, usable bits in flops.
`default_nettype none

module nca_table #(
  parameter int MAX_CENTERS = nca_pkg::MaxCentersDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(MAX_CENTERS)-1:0] wr_addr,
  input  wire nca_pkg::entry_t                wr_entry,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(MAX_CENTERS)-1:0] rd_addr,
  output nca_pkg::entry_t                     rd_entry
);
  import nca_pkg::*;

  logic [2*CoordBits-1:0] mem [MAX_CENTERS];
  logic [MAX_CENTERS-1:0] usable;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_entry.x, wr_entry.y};
    end
    if (rd_en) begin
      {rd_entry.x, rd_entry.y} <= mem[rd_addr];
      rd_entry.usable          <= usable[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable <= '0;
    end else if (wr_en) begin
      usable[wr_addr] <= wr_entry.usable;
    end
  end

endmodule

`default_nettype wire

@@ src/nca_search.sv @@
// Scan engine: walks the table one entry a cycle and keeps the nearest hit.
`default_nettype none

module nca_search #(
  parameter int MAX_CENTERS = nca_pkg::MaxCentersDef
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [$clog2(MAX_CENTERS):0]         scan_len,
  input  wire logic [nca_pkg::CapBits-1:0]          cap,
  input  wire logic signed [nca_pkg::CoordBits-1:0] px,
  input  wire logic signed [nca_pkg::CoordBits-1:0] py,
  output logic                                      rd_en,
  output logic [$clog2(MAX_CENTERS)-1:0]            rd_addr,
  input  wire nca_pkg::entry_t                      rd_entry,
  output nca_pkg::search_status_t                   status,
  output logic [$clog2(MAX_CENTERS)-1:0]            best_idx
);
  import nca_pkg::*;

  localparam int IdxW     = $clog2(MAX_CENTERS);
  localparam int DiffBits = CoordBits + 1;
  localparam int SqBits   = 2 * CoordBits + 1;
  localparam int DistBits = SqBits + 1;

  logic                       busy;
  logic [IdxW:0]              cnt;
  logic                       v1;
  logic [IdxW-1:0]            idx1;
  logic                       v2;
  logic                       use2;
  logic [IdxW-1:0]            idx2;
  logic [SqBits-1:0]          sqx;
  logic [SqBits-1:0]          sqy;
  logic [CapBits-1:0]         best;
  logic                       hit;
  logic signed [DiffBits-1:0] dx;
  logic signed [DiffBits-1:0] dy;
  logic signed [2*DiffBits-1:0] prod_x;
  logic signed [2*DiffBits-1:0] prod_y;
  logic [DistBits-1:0]        dist_sum;
  logic                       issue;

  assign issue   = busy && (cnt != scan_len);
  assign rd_en   = issue;
  assign rd_addr = cnt[IdxW-1:0];

  // stage 1: difference and square per axis
  assign dx     = DiffBits'(px) - DiffBits'(rd_entry.x);
  assign dy     = DiffBits'(py) - DiffBits'(rd_entry.y);
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  // stage 2: sum and compare
  assign dist_sum = DistBits'(sqx) + DistBits'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end else if (status.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= rd_addr;
    idx2 <= idx1;
    use2 <= rd_entry.usable;
    sqx  <= prod_x[SqBits-1:0];
    sqy  <= prod_y[SqBits-1:0];
  end

  // strict less-than: the lower index keeps a tie
  always_ff @(posedge clk) begin
    if (start) begin
      best     <= cap;
      best_idx <= '0;
      hit      <= 1'b0;
    end else if (v2 && use2 && (dist_sum < DistBits'(best))) begin
      best     <= dist_sum[CapBits-1:0];
      best_idx <= idx2;
      hit      <= 1'b1;
    end
  end

  assign status.done      = busy && !issue && !v1 && !v2;
  assign status.hit       = hit;
  assign status.best_dist = best;

endmodule

`default_nettype wire

@@ src/nca_checker.sv @@
// Port-level checker for the nearest-centre assignment block, with its bind.
`default_nettype none
`include "nearest_center_assign_top_assert.svh"

module nca_port_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire nca_pkg::item_t   item,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire nca_pkg::result_t result
);
  import nca_pkg::*;

  `NCA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed or dropped")

  `NCA_ASSERT_NOW(a_miss_index, result_valid && !result.found, result.nearest_index == '0, "not-found result with nonzero index")

  `NCA_ASSERT_NEXT(a_load_silent, item_valid && !item_stall && item.command == CMD_LOAD && !result_valid, !result_valid, "load beat produced a result")

  `NCA_ASSERT_NEXT(a_query_busy, item_valid && !item_stall && item.command == CMD_QUERY, item_stall, "query beat did not hold off the next item")

endmodule

bind nearest_center_assign_top nca_port_checker u_nca_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
